/* hw/rtl/cdll_pkg.sv */
// shared constants, opcodes and controller/datapath interface types for the cursor list
package cdll_pkg;

    localparam int POOL_NODES_DEF = 256;
    localparam int DATA_W         = 32;
    localparam logic [DATA_W-1:0] SENTINEL_READ = 32'd64;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_JUMP_START = 3'd0;
    localparam logic [OP_W-1:0] OP_JUMP_END   = 3'd1;
    localparam logic [OP_W-1:0] OP_STEP_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_STEP_FWD   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd5;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd6;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;

    typedef struct packed {
        logic accept;
        logic jump_start;
        logic jump_end;
        logic clear;
        logic pool_err;
        logic step_back;
        logic step_fwd;
        logic ins_alloc;
        logic ins_link;
        logic rm_unlink;
        logic rm_free;
    } cmd_t;

    typedef struct packed {
        logic pool_full;
        logic cur_is_data;
    } stat_t;

endpackage

/* hw/rtl/cdll_ctrl.sv */
// sequencer for the cursor list: decodes each request and steps the datapath through it
module cdll_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cdll_pkg::OP_W-1:0] opcode,
    input  cdll_pkg::stat_t           stat,
    output cdll_pkg::cmd_t            cmd,
    output logic                      busy,
    output logic                      done
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_STEP      = 3'd1;
    localparam logic [2:0] S_INS_ALLOC = 3'd2;
    localparam logic [2:0] S_INS_LINK  = 3'd3;
    localparam logic [2:0] S_RM_UNLINK = 3'd4;
    localparam logic [2:0] S_RM_FREE   = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       back_reg;
    logic       back_next;
    logic       accept;

    // the result cycle overlaps acceptance of the next request
    assign busy   = (state_reg != S_IDLE) && (state_reg != S_DONE);
    assign done   = (state_reg == S_DONE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        back_next  = back_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE, S_DONE:
            begin
                state_next = S_IDLE;
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DONE;
                    case (opcode)
                        cdll_pkg::OP_JUMP_START: cmd.jump_start = 1'b1;
                        cdll_pkg::OP_JUMP_END:   cmd.jump_end = 1'b1;
                        cdll_pkg::OP_STEP_BACK,
                        cdll_pkg::OP_STEP_FWD:
                        begin
                            back_next  = (opcode == cdll_pkg::OP_STEP_BACK);
                            state_next = S_STEP;
                        end
                        cdll_pkg::OP_READ: ;
                        cdll_pkg::OP_INSERT:
                        begin
                            if (stat.pool_full)
                            begin
                                cmd.pool_err = 1'b1;
                            end
                            else
                            begin
                                state_next = S_INS_ALLOC;
                            end
                        end
                        cdll_pkg::OP_REMOVE:
                        begin
                            if (stat.cur_is_data)
                            begin
                                state_next = S_RM_UNLINK;
                            end
                        end
                        cdll_pkg::OP_CLEAR: cmd.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_STEP:
            begin
                cmd.step_back = back_reg;
                cmd.step_fwd  = !back_reg;
                state_next    = S_DONE;
            end
            S_INS_ALLOC:
            begin
                cmd.ins_alloc = 1'b1;
                state_next    = S_INS_LINK;
            end
            S_INS_LINK:
            begin
                cmd.ins_link = 1'b1;
                state_next   = S_DONE;
            end
            S_RM_UNLINK:
            begin
                cmd.rm_unlink = 1'b1;
                state_next    = S_RM_FREE;
            end
            S_RM_FREE:
            begin
                cmd.rm_free = 1'b1;
                state_next  = S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            back_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            back_reg  <= back_next;
        end
    end

endmodule

/* hw/rtl/cdll_datapath.sv */
// node pool memories, sentinel links, cursor and free chain of the cursor list
module cdll_datapath
#(
    parameter int POOL_NODES = cdll_pkg::POOL_NODES_DEF,
    parameter int CW         = $clog2(POOL_NODES + 1)
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cdll_pkg::cmd_t                     cmd,
    input  logic signed [cdll_pkg::DATA_W-1:0] data_value,
    output cdll_pkg::stat_t                    stat,
    output logic signed [cdll_pkg::DATA_W-1:0] read_value,
    output logic                               cursor_at_start,
    output logic                               cursor_at_end,
    output logic                               list_empty,
    output logic                               pool_full_error,
    output logic [CW-1:0]                      element_count
);

    localparam int NODE_TOTAL = POOL_NODES + 2;
    localparam int LW = $clog2(NODE_TOTAL + 1);
    localparam int AW = $clog2(NODE_TOTAL);
    localparam logic [LW-1:0] START_NODE = '0;
    localparam logic [LW-1:0] END_NODE   = LW'(1);
    localparam logic [LW-1:0] FIRST_POOL = LW'(2);
    localparam logic [LW-1:0] NODE_LIMIT = LW'(NODE_TOTAL);
    localparam logic [CW-1:0] POOL_COUNT = CW'(POOL_NODES);

    logic [cdll_pkg::DATA_W-1:0] val_mem  [NODE_TOTAL];
    logic [LW-1:0]               next_mem [NODE_TOTAL];
    logic [LW-1:0]               prev_mem [NODE_TOTAL];

    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] start_next_reg, start_next_next;
    logic [LW-1:0] end_prev_reg, end_prev_next;
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [CW-1:0] wm_reg, wm_next;
    logic [CW-1:0] count_reg, count_next;
    logic          err_reg, err_next;

    logic [cdll_pkg::DATA_W-1:0] value_reg, value_next;
    logic [LW-1:0] n_reg, n_next;
    logic [LW-1:0] left_reg, left_next;
    logic [LW-1:0] right_reg, right_next;

    logic [cdll_pkg::DATA_W-1:0] val_q;
    logic [LW-1:0]               next_a_q;
    logic [LW-1:0]               next_b_q;
    logic [LW-1:0]               prev_q;

    logic [LW-1:0] left_w;
    logic [LW-1:0] fh_addr;
    logic [LW-1:0] right_ins;
    logic          seq_alloc;
    logic          cur_sentinel;

    logic                        val_we;
    logic [LW-1:0]               val_waddr;
    logic                        next_we;
    logic [LW-1:0]               next_waddr;
    logic [LW-1:0]               next_wdata;
    logic                        prev_we;
    logic [LW-1:0]               prev_waddr;
    logic [LW-1:0]               prev_wdata;

    // insert on the end sentinel links after the last node
    assign left_w       = (cur_reg == END_NODE) ? end_prev_reg : cur_reg;
    assign fh_addr      = (free_head_reg < NODE_LIMIT) ? free_head_reg : END_NODE;
    assign right_ins    = (left_w == START_NODE) ? start_next_reg : next_a_q;
    // nodes above the watermark were never handed out and need no chain read
    assign seq_alloc    = (wm_reg < POOL_COUNT) && (free_head_reg == FIRST_POOL + LW'(wm_reg));
    assign cur_sentinel = (cur_reg == START_NODE) || (cur_reg == END_NODE);

    always_comb
    begin
        cur_next        = cur_reg;
        start_next_next = start_next_reg;
        end_prev_next   = end_prev_reg;
        free_head_next  = free_head_reg;
        wm_next         = wm_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        value_next      = value_reg;
        n_next          = n_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        val_we          = 1'b0;
        val_waddr       = fh_addr;
        next_we         = 1'b0;
        next_waddr      = fh_addr;
        next_wdata      = right_ins;
        prev_we         = 1'b0;
        prev_waddr      = fh_addr;
        prev_wdata      = left_w;

        if (cmd.accept)
        begin
            value_next = data_value;
            err_next   = cmd.pool_err;
        end
        if (cmd.jump_start)
        begin
            cur_next = START_NODE;
        end
        if (cmd.jump_end)
        begin
            cur_next = END_NODE;
        end
        if (cmd.clear)
        begin
            cur_next        = END_NODE;
            start_next_next = END_NODE;
            end_prev_next   = START_NODE;
            free_head_next  = FIRST_POOL;
            wm_next         = '0;
            count_next      = '0;
        end
        if (cmd.step_back && (cur_reg != START_NODE))
        begin
            cur_next = (cur_reg == END_NODE) ? end_prev_reg : prev_q;
        end
        if (cmd.step_fwd && (cur_reg != END_NODE))
        begin
            cur_next = (cur_reg == START_NODE) ? start_next_reg : next_a_q;
        end
        if (cmd.ins_alloc)
        begin
            n_next         = fh_addr;
            left_next      = left_w;
            right_next     = right_ins;
            free_head_next = seq_alloc ? free_head_reg + LW'(1) : next_b_q;
            wm_next        = wm_reg + CW'(seq_alloc);
            val_we         = 1'b1;
            next_we        = 1'b1;
            prev_we        = 1'b1;
        end
        if (cmd.ins_link)
        begin
            if (right_reg == END_NODE)
            begin
                end_prev_next = n_reg;
            end
            else
            begin
                prev_we    = 1'b1;
                prev_waddr = right_reg;
                prev_wdata = n_reg;
            end
            if (left_reg == START_NODE)
            begin
                start_next_next = n_reg;
            end
            else
            begin
                next_we    = 1'b1;
                next_waddr = left_reg;
                next_wdata = n_reg;
            end
            count_next = count_reg + CW'(1);
            if (cur_reg != END_NODE)
            begin
                cur_next = n_reg;
            end
        end
        if (cmd.rm_unlink)
        begin
            right_next = next_a_q;
            if (next_a_q == END_NODE)
            begin
                end_prev_next = prev_q;
            end
            else
            begin
                prev_we    = 1'b1;
                prev_waddr = next_a_q;
                prev_wdata = prev_q;
            end
            if (prev_q == START_NODE)
            begin
                start_next_next = next_a_q;
            end
            else
            begin
                next_we    = 1'b1;
                next_waddr = prev_q;
                next_wdata = next_a_q;
            end
        end
        if (cmd.rm_free)
        begin
            next_we        = 1'b1;
            next_waddr     = cur_reg;
            next_wdata     = free_head_reg;
            free_head_next = cur_reg;
            if (count_reg != '0)
            begin
                count_next = count_reg - CW'(1);
            end
            cur_next = right_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= END_NODE;
            start_next_reg <= END_NODE;
            end_prev_reg   <= START_NODE;
            free_head_reg  <= FIRST_POOL;
            wm_reg         <= '0;
            count_reg      <= '0;
            err_reg        <= 1'b0;
        end
        else
        begin
            cur_reg        <= cur_next;
            start_next_reg <= start_next_next;
            end_prev_reg   <= end_prev_next;
            free_head_reg  <= free_head_next;
            wm_reg         <= wm_next;
            count_reg      <= count_next;
            err_reg        <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        n_reg     <= n_next;
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    // link reads run every cycle; the cycle after a request consumes them
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr[AW-1:0]] <= value_reg;
        end
        if (next_we)
        begin
            next_mem[next_waddr[AW-1:0]] <= next_wdata;
        end
        if (prev_we)
        begin
            prev_mem[prev_waddr[AW-1:0]] <= prev_wdata;
        end
        next_a_q <= next_mem[left_w[AW-1:0]];
        next_b_q <= next_mem[fh_addr[AW-1:0]];
        prev_q   <= prev_mem[cur_reg[AW-1:0]];
        val_q    <= val_mem[cur_next[AW-1:0]];
    end

    assign stat.pool_full   = (count_reg >= POOL_COUNT);
    assign stat.cur_is_data = !cur_sentinel;

    assign read_value      = cur_sentinel ? cdll_pkg::SENTINEL_READ : val_q;
    assign cursor_at_start = (cur_reg == START_NODE);
    assign cursor_at_end   = (cur_reg == END_NODE);
    assign list_empty      = (start_next_reg == END_NODE);
    assign pool_full_error = err_reg;
    assign element_count   = count_reg;

endmodule

/* hw/rtl/cursor_doubly_linked_list.sv */
// top level of the cursor list: controller and datapath
//
// Doubly linked list of signed 32-bit values in a pool of POOL_NODES nodes,
// bounded by start and end sentinels, with one cursor.
// Request channel: opcode and data_value are taken at a rising edge where
// start is high and busy is low.
// Result channel: done is high for exactly one cycle; read_value, the cursor
// flags, list_empty, pool_full_error and element_count are valid in that
// cycle. The receiver cannot stall; results must be taken when done is high.
// From the accepting edge, jump, read, clear, a dropped insert and a remove on
// a sentinel go straight to done; a step passes through the step state, an
// insert through the alloc and link states, a remove through the unlink and
// free states. A new request is accepted during the done cycle, not while
// busy is high. The step and the insert or remove sequences are set by the
// registered read of the link memories followed by the one-write-port
// updates of next and prev links. Reset (rst_n low) empties the list, puts the
// cursor on the end sentinel and needs no clearing pass; clear does the same.
module cursor_doubly_linked_list
#(
    parameter int POOL_NODES = cdll_pkg::POOL_NODES_DEF,
    parameter int CW         = $clog2(POOL_NODES + 1)
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [cdll_pkg::OP_W-1:0]          opcode,
    input  logic signed [cdll_pkg::DATA_W-1:0] data_value,
    output logic                               done,
    output logic signed [cdll_pkg::DATA_W-1:0] read_value,
    output logic                               cursor_at_start,
    output logic                               cursor_at_end,
    output logic                               list_empty,
    output logic                               pool_full_error,
    output logic [CW-1:0]                      element_count
);

    cdll_pkg::cmd_t  cmd;
    cdll_pkg::stat_t stat;

    cdll_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    cdll_datapath
    #(
        .POOL_NODES (POOL_NODES),
        .CW         (CW)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .data_value      (data_value),
        .stat            (stat),
        .read_value      (read_value),
        .cursor_at_start (cursor_at_start),
        .cursor_at_end   (cursor_at_end),
        .list_empty      (list_empty),
        .pool_full_error (pool_full_error),
        .element_count   (element_count)
    );

endmodule
